FILE: design/stc_pkg.sv
`timescale 1ns / 1ps
package stc_pkg;

  localparam int unsigned HALF_W = 14;

  localparam logic [2:0] MODE_NONE      = 3'd0;
  localparam logic [2:0] MODE_INIT      = 3'd1;
  localparam logic [2:0] MODE_STEER_ABS = 3'd2;
  localparam logic [2:0] MODE_STEER_REL = 3'd3;
  localparam logic [2:0] MODE_THR_ABS   = 3'd4;
  localparam logic [2:0] MODE_BRAKE     = 3'd5;
  localparam logic [2:0] MODE_FREEWHEEL = 3'd6;

  localparam logic signed [16:0] MAP_OFFSET = 17'sd1024;
  localparam logic signed [9:0]  THR_SPAN   = 10'sd510;
  localparam logic signed [31:0] THR_HALF   = 32'sd255;
  localparam int unsigned        MAP_SHIFT  = 11;

  // classified command, carried from the front end to the back end
  typedef struct packed {
    logic [2:0]         mode;
    logic               left_hit;
    logic               right_hit;
    logic signed [15:0] steer;
    logic               thr_rev;
    logic [7:0]         thr_duty;
  } stc_cmd_t;

endpackage

FILE: design/steer_throttle_command_controller.sv
`timescale 1ns / 1ps
// Steering stepper and throttle command controller.
// Input stream: one transfer is one control-loop pass carrying a command
// (mode, value) and the two steering limit switch states. Output stream:
// one result per pass with step pulse, direction, position, destination
// and the latched throttle direction, duty and enable.
// cfg_wr_en / cfg_wr_data write half_travel; write only while idle.
// Path: the input transfer is registered in the multiply stage, then the
// two-entry command queue, then the result register. Throughput: one pass
// per cycle while out_tready stays high; the back end updates its state as
// it takes each command from the queue.
// Reset clears position, destination, direction, enable, throttle latch,
// half_travel and all pipeline valids.
// When the receiver stalls the result register holds, the queue fills,
// and in_tready drops once the multiply stage has nowhere to go.
module steer_throttle_command_controller import stc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [HALF_W-1:0] cfg_wr_data,
  input  logic              in_tvalid,
  output logic              in_tready,
  // mode[2:0], value[18:3], left_limit_hit[19], right_limit_hit[20], zero pad
  input  logic [23:0]       in_tdata,
  output logic              out_tvalid,
  input  logic              out_tready,
  // step_pulse[0], step_dir_left[1], position[17:2], destination[33:18],
  // throttle_reverse[34], throttle_duty[42:35], throttle_on[43], zero pad
  output logic [47:0]       out_tdata
);

  stc_cmd_t    f_cmd, q_cmd;
  logic        f_valid, f_ready, q_valid, q_ready;
  logic [43:0] res_bits;

  stc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_mode     (in_tdata[2:0]),
    .in_value    (in_tdata[18:3]),
    .in_left     (in_tdata[19]),
    .in_right    (in_tdata[20]),
    .cmd_valid   (f_valid),
    .cmd_ready   (f_ready),
    .cmd         (f_cmd)
  );

  stc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_cmd)
  );

  stc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cmd       (q_cmd),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_bits  (res_bits)
  );

  assign out_tdata = {4'b0000, res_bits};

endmodule

FILE: design/stc_front.sv
`timescale 1ns / 1ps
module stc_front import stc_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [HALF_W-1:0]   cfg_wr_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          in_mode,
  input  logic signed [15:0]  in_value,
  input  logic                in_left,
  input  logic                in_right,
  output logic                cmd_valid,
  input  logic                cmd_ready,
  output stc_cmd_t            cmd
);

  logic [HALF_W-1:0]  half_r;
  logic               s1_v_r;
  logic [2:0]         s1_mode_r;
  logic               s1_left_r;
  logic               s1_right_r;
  logic signed [32:0] s1_sprod_r;
  logic signed [26:0] s1_tprod_r;

  logic signed [16:0] voff;
  logic signed [15:0] span2;
  logic               s1_adv;

  logic signed [31:0] sp, sq, sm, hs;
  logic signed [31:0] tp, tq, tm;
  logic signed [15:0] steer_c;
  logic signed [8:0]  thr_c;

  assign voff   = {in_value[15], in_value} + MAP_OFFSET;
  assign span2  = {1'b0, half_r, 1'b0};
  assign s1_adv = !s1_v_r || cmd_ready;
  assign in_ready = s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r <= '0;
      s1_v_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        half_r <= cfg_wr_data;
      end
      if (s1_adv) begin
        s1_v_r <= in_valid;
      end
    end
  end

  // products registered before the divide and clamp
  always_ff @(posedge clk) begin
    if (s1_adv && in_valid) begin
      s1_mode_r  <= in_mode;
      s1_left_r  <= in_left;
      s1_right_r <= in_right;
      s1_sprod_r <= voff * span2;
      s1_tprod_r <= voff * THR_SPAN;
    end
  end

  // truncating divide by 2048: bias negatives before the shift
  always_comb begin
    hs = {{(32-HALF_W){1'b0}}, half_r};
    sp = s1_sprod_r[31:0];
    sq = (sp + (sp[31] ? 32'sd2047 : 32'sd0)) >>> MAP_SHIFT;
    sm = sq - hs;
    if (sm < -hs) begin
      sm = -hs;
    end else if (sm > hs) begin
      sm = hs;
    end
    steer_c = sm[15:0];

    tp = {{5{s1_tprod_r[26]}}, s1_tprod_r};
    tq = (tp + (tp[31] ? 32'sd2047 : 32'sd0)) >>> MAP_SHIFT;
    tm = tq - THR_HALF;
    if (tm < -THR_HALF) begin
      tm = -THR_HALF;
    end else if (tm > THR_HALF) begin
      tm = THR_HALF;
    end
    thr_c = tm[8:0];
  end

  assign cmd_valid     = s1_v_r;
  assign cmd.mode      = s1_mode_r;
  assign cmd.left_hit  = s1_left_r;
  assign cmd.right_hit = s1_right_r;
  assign cmd.steer     = steer_c;
  assign cmd.thr_rev   = thr_c[8];
  assign cmd.thr_duty  = thr_c[8] ? 8'(-thr_c) : thr_c[7:0];

endmodule

FILE: design/stc_queue.sv
`timescale 1ns / 1ps
module stc_queue import stc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push_valid,
  output logic     push_ready,
  input  stc_cmd_t push_data,
  output logic     pop_valid,
  input  logic     pop_ready,
  output stc_cmd_t pop_data
);

  stc_cmd_t   mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  logic       do_push, do_pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_data   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: design/stc_back.sv
`timescale 1ns / 1ps
module stc_back import stc_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cmd_valid,
  output logic         cmd_ready,
  input  stc_cmd_t     cmd,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [43:0]  out_bits
);

  logic signed [15:0] pos_r, tgt_r;
  logic               dir_r, en_r, rev_r;
  logic [7:0]         duty_r;
  logic               out_v_r;
  logic [43:0]        out_r;

  logic signed [15:0] pos_nxt, tgt_nxt;
  logic               dir_nxt, en_nxt, rev_nxt, pulse;
  logic [7:0]         duty_nxt;
  logic signed [16:0] rel_sum;
  logic               load;

  assign load      = cmd_valid && (!out_v_r || out_ready);
  assign cmd_ready = load;

  always_comb begin
    pos_nxt  = pos_r;
    tgt_nxt  = tgt_r;
    dir_nxt  = dir_r;
    en_nxt   = en_r;
    rev_nxt  = rev_r;
    duty_nxt = duty_r;
    pulse    = 1'b0;
    rel_sum  = {tgt_r[15], tgt_r} + {cmd.steer[15], cmd.steer};

    // step toward the old target before the command runs
    if (tgt_r < pos_r) begin
      if (!cmd.left_hit) begin
        dir_nxt = 1'b1;
        pos_nxt = pos_r - 16'sd1;
        pulse   = 1'b1;
      end
    end else if (tgt_r > pos_r) begin
      if (!cmd.right_hit) begin
        dir_nxt = 1'b0;
        pos_nxt = pos_r + 16'sd1;
        pulse   = 1'b1;
      end
    end

    unique case (cmd.mode)
      MODE_INIT: begin
        en_nxt = 1'b1;
      end
      MODE_STEER_ABS: begin
        tgt_nxt = cmd.steer;
      end
      MODE_STEER_REL: begin
        if (rel_sum > 17'sd32767) begin
          tgt_nxt = 16'sh7fff;
        end else if (rel_sum < -17'sd32768) begin
          tgt_nxt = 16'sh8000;
        end else begin
          tgt_nxt = rel_sum[15:0];
        end
      end
      MODE_THR_ABS: begin
        if (en_r) begin
          rev_nxt  = cmd.thr_rev;
          duty_nxt = cmd.thr_duty;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      tgt_r   <= '0;
      dir_r   <= 1'b0;
      en_r    <= 1'b0;
      rev_r   <= 1'b0;
      duty_r  <= '0;
      out_v_r <= 1'b0;
    end else begin
      if (load) begin
        pos_r   <= pos_nxt;
        tgt_r   <= tgt_nxt;
        dir_r   <= dir_nxt;
        en_r    <= en_nxt;
        rev_r   <= rev_nxt;
        duty_r  <= duty_nxt;
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= {en_nxt, duty_nxt, rev_nxt, tgt_nxt, pos_nxt, dir_nxt, pulse};
    end
  end

  assign out_valid = out_v_r;
  assign out_bits  = out_r;

  a_pos_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !load |=> $stable(pos_r))
    else $error("position moved without a transfer");

  a_out_match: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (out_r[17:2] == pos_r && out_r[33:18] == tgt_r))
    else $error("result register disagrees with state");

  a_en_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    en_r |=> en_r)
    else $error("throttle enable dropped");

endmodule
